[rtl/assert_macros.svh]
// Assertion macros shared by the fan tachometer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

[rtl/ftach_pkg.sv]
// Package for the fan tachometer speed meter: widths, register indexes,
// reset values and the control/status types of the rate calculator.
package ftach_pkg;

   localparam int RING_DEPTH = 16;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   localparam int TIME_W     = 32;
   localparam int PPR_W      = 8;
   localparam int MINP_W     = 16;
   localparam int RPM_W      = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_PPR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MINP = 1'd1;

   localparam logic [PPR_W-1:0]  PPR_RST  = 8'd2;
   localparam logic [MINP_W-1:0] MINP_RST = 16'd1000;

   // 60 s/min * 1e6 us/s * 16 (four fraction bits)
   localparam int K_W = 30;
   localparam logic [K_W-1:0] US_PER_MIN_Q4 = 30'd960000000;

   localparam int NUM_W  = K_W + FILL_W;
   localparam int DEN_W  = PPR_W + TIME_W;
   localparam int QUOT_W = (NUM_W > RPM_W) ? NUM_W : RPM_W + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   localparam int CMD_EDGE = 0;

   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dt;
      logic [PPR_W-1:0]  ppr;
      logic [FILL_W-1:0] fill_m1;
   } ftach_calc_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ftach_calc_stat_type;

endpackage

[rtl/ftach_if.sv]
// Channel interfaces of the fan tachometer: request (edge or query) and
// response (speed). Depends on ftach_pkg.
interface ftach_req_if;
   import ftach_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [TIME_W-1:0] time_us;

   modport source (output valid, output cmd, output time_us, input ready);
   modport sink   (input valid, input cmd, input time_us, output ready);
endinterface

interface ftach_rsp_if;
   import ftach_pkg::*;
   logic             valid;
   logic             ready;
   logic             edge_taken;
   logic             speed_valid;
   logic [RPM_W-1:0] rpm_q4;

   modport source (output valid, output edge_taken, output speed_valid,
                   output rpm_q4, input ready);
   modport sink   (input valid, input edge_taken, input speed_valid,
                   input rpm_q4, output ready);
endinterface

[rtl/ftach_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftach_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/ftach_calc.sv]
// Speed calculator: bit-serial multiply of the pulse count per revolution by
// the span, then restoring division of (stored stamps-1)*960e6 by it, one bit per cycle.
// Depends on ftach_pkg.
module ftach_calc (
   input  logic                             clock,
   input  logic                             reset,
   input  ftach_pkg::ftach_calc_req_type    calc_req,
   output ftach_pkg::ftach_calc_stat_type   calc_stat,
   output logic [ftach_pkg::RPM_W-1:0]      rpm_q4
);
   import ftach_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PPR_W-1:0]  ppr_sr_ff, ppr_sr_in;
   logic [TIME_W-1:0] dt_ff, dt_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  num_sr_ff, num_sr_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              q_bit;

   assign trial = {rem_ff, num_sr_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign q_bit = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      ppr_sr_in = ppr_sr_ff;
      dt_in     = dt_ff;
      den_in    = den_ff;
      num_sr_in = num_sr_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      if (calc_req.start) begin
         busy_in   = 1'b1;
         div_in    = 1'b0;
         cnt_in    = CNT_W'(PPR_W);
         // a zero pulse count behaves as one pulse per revolution
         ppr_sr_in = (calc_req.ppr == '0) ? PPR_W'(1) : calc_req.ppr;
         dt_in     = calc_req.dt;
         den_in    = '0;
         num_sr_in = NUM_W'(calc_req.fill_m1) * NUM_W'(US_PER_MIN_Q4);
         rem_in    = '0;
         quot_in   = '0;
      end else if (busy_ff && !div_ff) begin
         // multiply, most significant multiplier bit first
         den_in    = {den_ff[DEN_W-2:0], 1'b0}
                     + (ppr_sr_ff[PPR_W-1] ? DEN_W'(dt_ff) : '0);
         ppr_sr_in = {ppr_sr_ff[PPR_W-2:0], 1'b0};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            div_in = 1'b1;
            cnt_in = CNT_W'(NUM_W);
         end
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in    = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_sr_in = {num_sr_ff[NUM_W-2:0], 1'b0};
         quot_in   = {quot_ff[QUOT_W-2:0], q_bit};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      ppr_sr_ff <= ppr_sr_in;
      dt_ff     <= dt_in;
      den_ff    <= den_in;
      num_sr_ff <= num_sr_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
   end

   // clamp to the field maximum
   assign rpm_q4 = (|quot_ff[QUOT_W-1:RPM_W]) ? '1 : quot_ff[RPM_W-1:0];

   assign calc_stat.busy = busy_ff;
   assign calc_stat.done = done_ff;
endmodule

[rtl/fan_tach_rpm_meter.sv]
// Fan tachometer speed meter, top level: edge filter, timestamp ring,
// sequencer and result register. Depends on ftach_pkg, ftach_if,
// ftach_ram, ftach_calc and assert_macros.svh.
//
//   channel   | direction | transfer carries
//   ----------+-----------+--------------------------------------------
//   req_chan  | in        | cmd (0 edge, 1 query), time_us
//   rsp_chan  | out       | edge_taken, speed_valid, rpm_q4
//   csr_*     | in        | write of pulse count per rev (0) or minimum gap (1)
//
// One item at a time. An item without a valid speed goes from transfer through
// the S_READ, S_LOAD and S_DONE states to the output register; one with a speed
// also passes S_CALC, where it waits on the bit-serial multiply and the
// one-bit-per-cycle divider in ftach_calc, then picks up its result.
// Reset is synchronous; the ring needs no clearing.
// A result waiting on rsp_chan does not block the next request; only the
// move of a new result into the output register waits for the sink.
`include "assert_macros.svh"

module fan_tach_rpm_meter (
   input  logic                              clock,
   input  logic                              reset,
   ftach_req_if.sink                         req_chan,
   ftach_rsp_if.source                       rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ftach_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ftach_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ftach_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam int IDX_W = FILL_W + 1;

   logic [2:0]        state_ff, state_in;
   logic [PPR_W-1:0]  ppr_ff, ppr_in;
   logic [MINP_W-1:0] minp_ff, minp_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;

   logic              taken_ff, taken_in;
   logic              spd_ok_ff, spd_ok_in;
   logic [RPM_W-1:0]  rpm_ff, rpm_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_taken_ff, out_taken_in;
   logic              out_spd_ok_ff, out_spd_ok_in;
   logic [RPM_W-1:0]  out_rpm_ff, out_rpm_in;

   logic              req_fire;
   logic              edge_ok;
   logic [TIME_W-1:0] gap;
   logic [IDX_W-1:0]  old_sum;
   logic [IDX_W-1:0]  old_idx;
   logic [PTR_W-1:0]  old_ptr;
   logic [TIME_W-1:0] old_stamp;
   logic [TIME_W-1:0] span;
   logic              span_ok;
   logic              out_free;

   ftach_calc_req_type  calc_req;
   ftach_calc_stat_type calc_stat;
   logic [RPM_W-1:0]    calc_rpm;

   // Accept only when the sequencer is free.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Reject edges closer than the minimum gap to the last stored one (wrapping).
   assign gap     = req_chan.time_us - last_edge_ff;
   assign edge_ok = (req_chan.cmd == 1'(CMD_EDGE)) && (gap >= TIME_W'(minp_ff));

   // Oldest stored entry: write pointer minus fill, modulo ring depth.
   assign old_sum = IDX_W'(wptr_ff) + IDX_W'(RING_DEPTH) - IDX_W'(fill_ff);
   assign old_idx = (old_sum >= IDX_W'(RING_DEPTH)) ? old_sum - IDX_W'(RING_DEPTH)
                                                    : old_sum;
   assign old_ptr = old_idx[PTR_W-1:0];

   ftach_ram #(
      .WIDTH (TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire && edge_ok),
      .wr_addr (wptr_ff),
      .wr_data (req_chan.time_us),
      .rd_addr (old_ptr),
      .rd_data (old_stamp)
   );

   // The newest stored stamp is always the last accepted edge time.
   assign span    = last_edge_ff - old_stamp;
   assign span_ok = (fill_ff >= FILL_W'(2)) && (span != '0);

   assign calc_req.start   = (state_ff == S_LOAD) && span_ok;
   assign calc_req.dt      = span;
   assign calc_req.ppr     = ppr_ff;
   assign calc_req.fill_m1 = fill_ff - 1'b1;

   ftach_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .calc_req  (calc_req),
      .calc_stat (calc_stat),
      .rpm_q4    (calc_rpm)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Configuration writes; the user must write only while the block is idle (not enforced here).
   always_comb begin
      ppr_in  = ppr_ff;
      minp_in = minp_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PPR:  ppr_in  = csr_wdata[PPR_W-1:0];
            REG_MINP: minp_in = csr_wdata[MINP_W-1:0];
            default:  ;
         endcase
      end
   end

   // Ring bookkeeping: advance the pointer, saturate the fill count.
   always_comb begin
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      last_edge_in = last_edge_ff;
      if (req_fire && edge_ok) begin
         wptr_in      = (wptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         fill_in      = (fill_ff == FILL_W'(RING_DEPTH)) ? fill_ff : fill_ff + 1'b1;
         last_edge_in = req_chan.time_us;
      end
   end

   // Sequencer and result staging.
   always_comb begin
      state_in      = state_ff;
      taken_in      = taken_ff;
      spd_ok_in     = spd_ok_ff;
      rpm_in        = rpm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_taken_in  = out_taken_ff;
      out_spd_ok_in = out_spd_ok_ff;
      out_rpm_in    = out_rpm_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               taken_in = edge_ok;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // hold the oldest-entry address while the RAM registers it
            state_in = S_LOAD;
         end
         S_LOAD: begin
            spd_ok_in = span_ok;
            rpm_in    = '0;
            state_in  = span_ok ? S_CALC : S_DONE;
         end
         S_CALC: begin
            if (calc_stat.done) begin
               rpm_in   = calc_rpm;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_taken_in  = taken_ff;
               out_spd_ok_in = spd_ok_ff;
               out_rpm_in    = rpm_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ppr_ff       <= PPR_RST;
         minp_ff      <= MINP_RST;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         last_edge_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ppr_ff       <= ppr_in;
         minp_ff      <= minp_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         last_edge_ff <= last_edge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      taken_ff      <= taken_in;
      spd_ok_ff     <= spd_ok_in;
      rpm_ff        <= rpm_in;
      out_taken_ff  <= out_taken_in;
      out_spd_ok_ff <= out_spd_ok_in;
      out_rpm_ff    <= out_rpm_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.edge_taken  = out_taken_ff;
   assign rsp_chan.speed_valid = out_spd_ok_ff;
   assign rsp_chan.rpm_q4      = out_rpm_ff;

   `ASSERT_RST(a_fill_cap, clock, reset, fill_ff <= FILL_W'(RING_DEPTH))
   `ASSERT_NEXT(a_drop_keeps_ring, clock, reset, !(req_fire && edge_ok), (fill_ff == $past(fill_ff)) && (last_edge_ff == $past(last_edge_ff)))
   `ASSERT_RST(a_calc_in_seq, clock, reset, !calc_stat.busy || (state_ff == S_CALC))
   `ASSERT_RST(a_no_speed_zero, clock, reset, !rsp_valid_ff || out_spd_ok_ff || (out_rpm_ff == '0))
endmodule

[tb/testbench.sv]
// Self-checking testbench for fan_tach_rpm_meter: drives edge and query
// transfers, predicts each speed result and compares it with the block.
// Depends on ftach_pkg, ftach_if and the RTL of the speed meter.
module testbench;
   import ftach_pkg::*;

   // Command codes of the request channel.
   localparam logic CMD_TACH  = 1'(CMD_EDGE);
   localparam logic CMD_QUERY = ~CMD_TACH;

   // Microseconds per minute times 16 (four fraction bits of rpm).
   localparam longint unsigned USEC_PER_MIN_X16 = 64'd60 * 64'd1000000 * 64'd16;

   // Allowance for the time from transfer to speed result.
   localparam int SPEED_LAT   = 4 + 8 + NUM_W;
   localparam int STUCK_LIMIT = 2000;
   localparam int PHASE_ITEMS = 75;

   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] time_us;
   } tach_item_type;

   typedef struct packed {
      logic             edge_taken;
      logic             speed_valid;
      logic [RPM_W-1:0] rpm_q4;
   } speed_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ftach_req_if tach_in ();
   ftach_rsp_if speed_out ();

   fan_tach_rpm_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (tach_in),
      .rsp_chan  (speed_out),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Items waiting to be sent, and speeds owed by the block in order.
   tach_item_type tach_pending_q[$];
   speed_rsp_type speed_due_q[$];

   int queued_total;
   int accepted_total;
   int fault_count;
   int stuck_cycles;
   int send_gap;
   int stall_left;
   bit pacing;
   logic [TIME_W-1:0] tl_us;   // running timeline of generated edges

   // Shadow of the meter: timestamp ring, pointers and registers.
   logic [TIME_W-1:0] stamp_ring [RING_DEPTH];
   logic [PTR_W-1:0]  wr_ptr;
   logic [FILL_W-1:0] fill;
   logic [TIME_W-1:0] last_stamp;
   logic [PPR_W-1:0]  rev_pulses;
   logic [MINP_W-1:0] min_gap;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one accepted item to the shadow state and return the speed
   // the block must report for it.
   function automatic speed_rsp_type predict_speed(input tach_item_type it);
      speed_rsp_type     r;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] span;
      logic [PTR_W-1:0]  newest;
      logic [PTR_W-1:0]  oldest;
      logic [PPR_W-1:0]  ppr_eff;
      logic [63:0]       num;
      logic [63:0]       den;
      logic [63:0]       quo;
      r = '0;
      gap = it.time_us - last_stamp;
      // Take the edge only when the wrapped gap reaches the minimum.
      if (it.cmd == CMD_TACH && gap >= TIME_W'(min_gap)) begin
         stamp_ring[wr_ptr] = it.time_us;
         wr_ptr = wr_ptr + 1'b1;
         if (fill < FILL_W'(RING_DEPTH))
            fill = fill + 1'b1;
         last_stamp = it.time_us;
         r.edge_taken = 1'b1;
      end
      if (fill >= FILL_W'(2)) begin
         newest = wr_ptr - 1'b1;
         oldest = wr_ptr - fill[PTR_W-1:0];   // a full ring wraps to wr_ptr
         span = stamp_ring[newest] - stamp_ring[oldest];
         if (span != '0) begin
            // A zero pulse count behaves as one pulse per revolution.
            ppr_eff = (rev_pulses == '0) ? PPR_W'(1) : rev_pulses;
            num = 64'(fill - 1'b1) * USEC_PER_MIN_X16;
            den = 64'(ppr_eff) * 64'(span);
            quo = num / den;
            r.speed_valid = 1'b1;
            r.rpm_q4 = (quo > 64'hFFFF_FFFF) ? '1 : quo[RPM_W-1:0];
         end
      end
      return r;
   endfunction

   // Request driver: present queued items, insert random gaps after a
   // transfer when pacing is on, and predict at each accepted transfer.
   always @(posedge clock) begin : tach_feed
      tach_item_type next_item;
      if (reset) begin
         tach_in.valid   <= 1'b0;
         tach_in.cmd     <= CMD_QUERY;
         tach_in.time_us <= '0;
         send_gap        <= 0;
      end else begin
         if (tach_in.valid && tach_in.ready) begin
            speed_due_q.push_back(predict_speed({tach_in.cmd, tach_in.time_us}));
            accepted_total++;
         end
         // Advance only once the current item has been taken or none is up.
         if (!tach_in.valid || tach_in.ready) begin
            if (send_gap != 0) begin
               send_gap      <= send_gap - 1;
               tach_in.valid <= 1'b0;
            end else if (tach_pending_q.size() != 0) begin
               next_item = tach_pending_q.pop_front();
               tach_in.valid   <= 1'b1;
               tach_in.cmd     <= next_item.cmd;
               tach_in.time_us <= next_item.time_us;
               if (pacing && $urandom_range(0, 3) == 0)
                  send_gap <= $urandom_range(1, 18);
            end else begin
               tach_in.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest owed speed and
   // stall the channel in random bursts when pacing is on.
   always @(posedge clock) begin : speed_check
      speed_rsp_type want;
      if (reset) begin
         speed_out.ready <= 1'b0;
         stall_left      <= 0;
      end else begin
         if (speed_out.valid && speed_out.ready) begin
            if (speed_due_q.size() == 0) begin
               $error("speed result with nothing pending");
               fault_count++;
            end else begin
               want = speed_due_q.pop_front();
               if (speed_out.edge_taken !== want.edge_taken) begin
                  $error("edge_taken: expected %0d, got %0d",
                         want.edge_taken, speed_out.edge_taken);
                  fault_count++;
               end
               if (speed_out.speed_valid !== want.speed_valid) begin
                  $error("speed_valid: expected %0d, got %0d",
                         want.speed_valid, speed_out.speed_valid);
                  fault_count++;
               end
               if (speed_out.rpm_q4 !== want.rpm_q4) begin
                  $error("rpm_q4: expected %0d, got %0d",
                         want.rpm_q4, speed_out.rpm_q4);
                  fault_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            speed_out.ready <= 1'b0;
         end else begin
            speed_out.ready <= 1'b1;
            if (pacing && $urandom_range(0, 5) == 0)
               stall_left <= $urandom_range(1, 18);
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either side for
   // far longer than the slowest item with the longest gap and stall.
   always @(posedge clock) begin : hang_watch
      if (reset || (tach_in.valid && tach_in.ready) || (speed_out.valid && speed_out.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic push_item(input logic cmd, input logic [TIME_W-1:0] t);
      tach_pending_q.push_back({cmd, t});
      queued_total++;
   endtask

   // Hold until every queued item is taken and every speed has come back,
   // then let the block's longest latency pass.
   task automatic settle();
      while (accepted_total != queued_total || speed_due_q.size() != 0)
         @(posedge clock);
      repeat (SPEED_LAT + 8) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges; call only when idle.
   task automatic program_meter(input logic [PPR_W-1:0] ppr, input logic [MINP_W-1:0] gap_us);
      csr_wr_en <= 1'b1;
      csr_index <= REG_PPR;
      csr_wdata <= CSR_DATA_W'(ppr);
      @(posedge clock);
      csr_index <= REG_MINP;
      csr_wdata <= gap_us;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rev_pulses = ppr;
      min_gap    = gap_us;
   endtask

   // Queue a mix of sequences: mostly clean tach runs with the odd speed
   // query, plus glitch runs, tight bursts, stray noise and query bursts.
   task automatic queue_phase(input int n);
      int                goal;
      int                pick;
      int                run_len;
      int                k;
      bit                wide;
      bit                zero_run;
      logic [TIME_W-1:0] gap;
      goal = queued_total + n;
      while (queued_total < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // Clean run at a roughly steady fan speed.
            run_len = $urandom_range(3, 24);
            wide = ($urandom_range(0, 3) == 0);
            for (k = 0; k < run_len; k++) begin
               gap = TIME_W'(min_gap) +
                     (wide ? $urandom_range(0, 200000) : $urandom_range(0, 2000));
               if ($urandom_range(0, 49) == 0)
                  gap = $urandom >> 1;
               tl_us = tl_us + gap;
               push_item(CMD_TACH, tl_us);
               if ($urandom_range(0, 3) == 0)
                  push_item(CMD_QUERY, $urandom);
            end
         end else if (pick < 70) begin
            // Run broken by glitches shorter than the minimum gap.
            run_len = $urandom_range(4, 16);
            for (k = 0; k < run_len; k++) begin
               if (min_gap != '0 && $urandom_range(0, 1) == 0)
                  gap = $urandom_range(0, min_gap - 1);
               else
                  gap = TIME_W'(min_gap) + $urandom_range(0, 5000);
               tl_us = tl_us + gap;
               push_item(CMD_TACH, tl_us);
            end
         end else if (pick < 80) begin
            // Tight burst: fills the ring at one stamp (zero span) or
            // nearly so (saturated speed) when the minimum gap allows.
            run_len  = $urandom_range(16, 20);
            zero_run = $urandom_range(0, 1);
            for (k = 0; k < run_len; k++) begin
               gap = zero_run ? '0 : TIME_W'($urandom_range(0, 2));
               tl_us = tl_us + gap;
               push_item(CMD_TACH, tl_us);
            end
            push_item(CMD_QUERY, $urandom);
         end else if (pick < 90) begin
            // Stray items with arbitrary command and stamp.
            run_len = $urandom_range(1, 4);
            for (k = 0; k < run_len; k++)
               push_item(1'($urandom), $urandom);
         end else begin
            run_len = $urandom_range(1, 5);
            for (k = 0; k < run_len; k++)
               push_item(CMD_QUERY, $urandom);
         end
      end
   endtask

   task automatic run_phase(input logic [PPR_W-1:0] ppr, input logic [MINP_W-1:0] gap_us,
                            input bit pace);
      program_meter(ppr, gap_us);
      pacing = pace;
      tl_us  = $urandom;
      queue_phase(PHASE_ITEMS);
      settle();
   endtask

   initial begin
      // Drive every input to a known value from time zero.
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_PPR;
      csr_wdata         = '0;
      tach_in.valid     = 1'b0;
      tach_in.cmd       = CMD_QUERY;
      tach_in.time_us   = '0;
      speed_out.ready   = 1'b0;
      queued_total      = 0;
      accepted_total    = 0;
      fault_count       = 0;
      stuck_cycles      = 0;
      send_gap          = 0;
      stall_left        = 0;
      pacing            = 1'b1;
      tl_us             = '0;
      wr_ptr            = '0;
      fill              = '0;
      last_stamp        = '0;
      rev_pulses        = PPR_RST;
      min_gap           = MINP_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      push_item(CMD_QUERY, 32'h0000_0000);   // empty ring, no speed
      push_item(CMD_TACH,  32'h0000_0000);   // too soon after time zero
      push_item(CMD_TACH,  32'd999);         // one short of the minimum
      push_item(CMD_TACH,  32'd1000);        // exactly the minimum, first edge
      push_item(CMD_QUERY, 32'hFFFF_FFFF);   // one edge only, stamp ignored
      push_item(CMD_TACH,  32'd1999);        // glitch
      push_item(CMD_TACH,  32'd2000);        // first valid speed
      push_item(CMD_TACH,  32'd602000);      // slow edge
      push_item(CMD_TACH,  32'hFFFF_FFFF);   // largest stamp
      push_item(CMD_TACH,  32'd512);         // wrapped glitch
      push_item(CMD_TACH,  32'd999);         // wrapped gap of exactly 1000
      push_item(CMD_QUERY, 32'hA5A5_5A5A);
      settle();

      // Random phases across register settings, extremes first. The
      // fourth phase runs without idling; the last one does too.
      run_phase(8'd1,   16'd0,     1'b1);
      run_phase(8'd255, 16'hFFFF,  1'b1);
      run_phase(8'd0,   16'd0,     1'b1);
      run_phase(8'd2,   16'd1000,  1'b0);
      run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)), 1'b1);
      run_phase(8'($urandom_range(1, 16)),  16'($urandom_range(0, 3000)),  1'b1);
      run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(0, 200)),   1'b1);
      run_phase(8'd4,   16'd1,     1'b0);

      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
